/* rtl/scl_pkg.sv */
package scl_pkg;

    // field widths
    localparam int RX_W    = 8;
    localparam int PERIOD_W = 16;
    localparam int VALUE_W = 10;
    localparam int ACC_W   = 11;
    localparam int PULSE_W = 16;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 16;

    // register reset values
    localparam logic [PERIOD_W-1:0] PERIOD_RST    = 16'd22726;
    localparam logic [VALUE_W-1:0]  PITCH_MIN_RST = 10'd20;
    localparam logic [VALUE_W-1:0]  PITCH_MAX_RST = 10'd110;
    localparam logic [VALUE_W-1:0]  YAW_MIN_RST   = 10'd20;
    localparam logic [VALUE_W-1:0]  YAW_MAX_RST   = 10'd160;

    // saturation limit of the decimal accumulator
    localparam logic [ACC_W-1:0] ACC_MAX = 11'd2047;

    // divide by 1000: floor(p * RECIP_1000 / 2^RECIP_SHIFT) is exact for p < 2^26
    localparam int PROD_W = VALUE_W + PERIOD_W;
    localparam int RECIP_SHIFT = 36;
    localparam int RECIP_W = 27;
    localparam logic [RECIP_W-1:0] RECIP_1000 = 27'd68719477;
    localparam int QUOT_W = PROD_W + RECIP_W - RECIP_SHIFT;

    // byte codes
    localparam logic [RX_W-1:0] CH_LF    = 8'h0A;
    localparam logic [RX_W-1:0] CH_CR    = 8'h0D;
    localparam logic [RX_W-1:0] CH_SPACE = 8'h20;
    localparam logic [RX_W-1:0] CH_TAB   = 8'h09;
    localparam logic [RX_W-1:0] CH_VT    = 8'h0B;
    localparam logic [RX_W-1:0] CH_FF    = 8'h0C;
    localparam logic [RX_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [RX_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [RX_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [RX_W-1:0] CH_NINE  = 8'h39;
    localparam logic [RX_W-1:0] CH_P_LO  = 8'h70;
    localparam logic [RX_W-1:0] CH_P_UP  = 8'h50;
    localparam logic [RX_W-1:0] CH_Y_LO  = 8'h79;
    localparam logic [RX_W-1:0] CH_Y_UP  = 8'h59;

    // axis codes on the result
    localparam logic AXIS_PITCH = 1'b0;
    localparam logic AXIS_YAW   = 1'b1;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PWM_PERIOD = 3'd0,
        REG_PITCH_MIN  = 3'd1,
        REG_PITCH_MAX  = 3'd2,
        REG_YAW_MIN    = 3'd3,
        REG_YAW_MAX    = 3'd4
    } t_cfg_reg;

    typedef enum logic [1:0] {
        PH_START,
        PH_LEAD,
        PH_DIGITS,
        PH_DONE
    } t_phase;

    typedef enum logic [1:0] {
        KIND_NONE,
        KIND_PITCH,
        KIND_YAW
    } t_kind;

endpackage

/* rtl/scl_rx_if.sv */
interface scl_rx_if;
    logic                     valid;
    logic                     ready;
    logic [scl_pkg::RX_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

/* rtl/scl_res_if.sv */
interface scl_res_if;
    logic                        valid;
    logic                        ready;
    logic                        axis;
    logic [scl_pkg::PULSE_W-1:0] pulse_width;
    logic [scl_pkg::VALUE_W-1:0] angle_value;

    modport source (output valid, output axis, output pulse_width, output angle_value,
                    input ready);
    modport sink (input valid, input axis, input pulse_width, input angle_value,
                  output ready);
endinterface

/* rtl/scl_cfg_if.sv */
interface scl_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [scl_pkg::CFG_IDX_W-1:0]  index;
    logic [scl_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

/* rtl/servo_command_line_parser.sv */
// Servo command line parser. Takes one received byte per cycle unless all three result
// slots are full and stalled, and parses text lines ending in LF or CR: a first byte
// of p/P selects pitch, y/Y selects yaw, followed by an atoi-style decimal value
// (leading blanks, optional sign, digits, magnitude saturating at 2047). At a line end
// whose value lies inside the axis window [min, max] one result is produced: the axis,
// the value and the pulse width value*pwm_period/1000 (saturated at 65535). The
// transfer edge of the line end byte latches the checked value in the first slot, the
// second slot holds the value-by-period product and the output slot the reciprocal
// multiply that divides by 1000. These three result slots buffer the path, so input
// keeps flowing while a result waits to be taken. Configuration writes are always
// taken at once and must only be made while no result is in flight; an unknown
// register index is ignored.
module servo_command_line_parser (
    input  logic  i_clk,
    input  logic  i_rst_n,
    scl_rx_if.sink      i_rx,
    scl_cfg_if.sink     i_cfg,
    scl_res_if.source   o_res
);
    import scl_pkg::*;

    // configuration registers
    logic [PERIOD_W-1:0] r_period;
    logic [VALUE_W-1:0]  r_pitch_min;
    logic [VALUE_W-1:0]  r_pitch_max;
    logic [VALUE_W-1:0]  r_yaw_min;
    logic [VALUE_W-1:0]  r_yaw_max;

    // line parse state
    t_phase           r_phase, n_phase;
    t_kind            r_kind, n_kind;
    logic             r_neg, n_neg;
    logic [ACC_W-1:0] r_acc, n_acc;

    // result pipeline
    logic               r_s1_valid;
    logic               r_s1_axis;
    logic [VALUE_W-1:0] r_s1_value;
    logic               r_s2_valid;
    logic               r_s2_axis;
    logic [VALUE_W-1:0] r_s2_value;
    logic [PROD_W-1:0]  r_s2_prod;
    logic               r_out_valid;
    logic               r_out_axis;
    logic [VALUE_W-1:0] r_out_value;
    logic [PULSE_W-1:0] r_out_pulse;

    logic s1_ready, s2_ready, out_ready;
    logic rx_xfer;
    logic is_eol, is_digit, is_blank;
    logic [3:0] digit;
    logic [ACC_W+3:0] acc_next;
    logic [VALUE_W-1:0] lo, hi;
    logic hit;
    logic [PROD_W+RECIP_W-1:0] recip_prod;
    logic [QUOT_W-1:0] quot;
    logic [PULSE_W-1:0] pulse_sat;

    // handshakes
    assign out_ready = !r_out_valid || o_res.ready;
    assign s2_ready  = !r_s2_valid || out_ready;
    assign s1_ready  = !r_s1_valid || s2_ready;
    assign i_rx.ready  = s1_ready;
    assign i_cfg.ready = 1'b1;
    assign rx_xfer = i_rx.valid && s1_ready;

    // byte classes
    assign is_eol   = (i_rx.rx_byte == CH_LF) || (i_rx.rx_byte == CH_CR);
    assign is_digit = (i_rx.rx_byte >= CH_ZERO) && (i_rx.rx_byte <= CH_NINE);
    assign is_blank = (i_rx.rx_byte == CH_SPACE) || (i_rx.rx_byte == CH_TAB) ||
                      (i_rx.rx_byte == CH_VT) || (i_rx.rx_byte == CH_FF);
    assign digit    = 4'(i_rx.rx_byte - CH_ZERO);
    assign acc_next = (ACC_W+4)'(r_acc) * (ACC_W+4)'(10) + (ACC_W+4)'(digit);

    // window check at line end
    assign lo  = (r_kind == KIND_PITCH) ? r_pitch_min : r_yaw_min;
    assign hi  = (r_kind == KIND_PITCH) ? r_pitch_max : r_yaw_max;
    assign hit = is_eol && (r_kind == KIND_PITCH || r_kind == KIND_YAW) &&
                 !(r_neg && r_acc != '0) &&
                 (r_acc <= {1'b0, hi}) && (r_acc >= {1'b0, lo});

    // next phase
    always_comb begin
        n_phase = r_phase;
        if (is_eol) begin
            n_phase = PH_START;
        end else begin
            unique case (r_phase)
                PH_START: begin
                    if (i_rx.rx_byte == CH_P_LO || i_rx.rx_byte == CH_P_UP ||
                        i_rx.rx_byte == CH_Y_LO || i_rx.rx_byte == CH_Y_UP) begin
                        n_phase = PH_LEAD;
                    end else begin
                        n_phase = PH_DONE;
                    end
                end
                PH_LEAD: begin
                    priority if (is_blank) begin
                        n_phase = PH_LEAD;
                    end else if (i_rx.rx_byte == CH_MINUS || i_rx.rx_byte == CH_PLUS ||
                                 is_digit) begin
                        n_phase = PH_DIGITS;
                    end else begin
                        n_phase = PH_DONE;
                    end
                end
                PH_DIGITS: begin
                    if (!is_digit) begin
                        n_phase = PH_DONE;
                    end
                end
                PH_DONE: n_phase = PH_DONE;
                default: n_phase = PH_DONE;
            endcase
        end
    end

    // next kind, sign and accumulator
    always_comb begin
        n_kind = r_kind;
        n_neg  = r_neg;
        n_acc  = r_acc;
        if (is_eol) begin
            n_kind = KIND_NONE;
            n_neg  = 1'b0;
            n_acc  = '0;
        end else begin
            unique case (r_phase)
                PH_START: begin
                    priority if (i_rx.rx_byte == CH_P_LO || i_rx.rx_byte == CH_P_UP) begin
                        n_kind = KIND_PITCH;
                    end else if (i_rx.rx_byte == CH_Y_LO || i_rx.rx_byte == CH_Y_UP) begin
                        n_kind = KIND_YAW;
                    end else begin
                        n_kind = KIND_NONE;
                    end
                end
                PH_LEAD: begin
                    priority if (i_rx.rx_byte == CH_MINUS) begin
                        n_neg = 1'b1;
                    end else if (is_digit) begin
                        n_acc = ACC_W'(digit);
                    end else begin
                        n_acc = r_acc;
                    end
                end
                PH_DIGITS: begin
                    if (is_digit) begin
                        n_acc = (acc_next > (ACC_W+4)'(ACC_MAX)) ? ACC_MAX
                                                                 : acc_next[ACC_W-1:0];
                    end
                end
                PH_DONE: n_acc = r_acc;
                default: n_acc = r_acc;
            endcase
        end
    end

    // divide by 1000 with a reciprocal multiply, then saturate
    assign recip_prod = (PROD_W+RECIP_W)'(r_s2_prod) * (PROD_W+RECIP_W)'(RECIP_1000);
    assign quot       = recip_prod[PROD_W+RECIP_W-1:RECIP_SHIFT];
    assign pulse_sat  = (quot > QUOT_W'({PULSE_W{1'b1}})) ? {PULSE_W{1'b1}}
                                                           : quot[PULSE_W-1:0];

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_START;
            r_kind      <= KIND_NONE;
            r_neg       <= 1'b0;
            r_acc       <= '0;
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_period    <= PERIOD_RST;
            r_pitch_min <= PITCH_MIN_RST;
            r_pitch_max <= PITCH_MAX_RST;
            r_yaw_min   <= YAW_MIN_RST;
            r_yaw_max   <= YAW_MAX_RST;
        end else begin
            if (rx_xfer) begin
                r_phase <= n_phase;
                r_kind  <= n_kind;
                r_neg   <= n_neg;
                r_acc   <= n_acc;
            end
            if (s1_ready) begin
                r_s1_valid <= rx_xfer && hit;
            end
            if (s2_ready) begin
                r_s2_valid <= r_s1_valid;
            end
            if (out_ready) begin
                r_out_valid <= r_s2_valid;
            end
            // configuration transfer
            if (i_cfg.valid) begin
                unique case (i_cfg.index)
                    REG_PWM_PERIOD: r_period    <= i_cfg.data;
                    REG_PITCH_MIN:  r_pitch_min <= i_cfg.data[VALUE_W-1:0];
                    REG_PITCH_MAX:  r_pitch_max <= i_cfg.data[VALUE_W-1:0];
                    REG_YAW_MIN:    r_yaw_min   <= i_cfg.data[VALUE_W-1:0];
                    REG_YAW_MAX:    r_yaw_max   <= i_cfg.data[VALUE_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (s1_ready && rx_xfer && hit) begin
            r_s1_axis  <= (r_kind == KIND_YAW) ? AXIS_YAW : AXIS_PITCH;
            r_s1_value <= r_acc[VALUE_W-1:0];
        end
        if (s2_ready && r_s1_valid) begin
            r_s2_axis  <= r_s1_axis;
            r_s2_value <= r_s1_value;
            r_s2_prod  <= PROD_W'(r_s1_value) * PROD_W'(r_period);
        end
        if (out_ready && r_s2_valid) begin
            r_out_axis  <= r_s2_axis;
            r_out_value <= r_s2_value;
            r_out_pulse <= pulse_sat;
        end
    end

    assign o_res.valid       = r_out_valid;
    assign o_res.axis        = r_out_axis;
    assign o_res.pulse_width = r_out_pulse;
    assign o_res.angle_value = r_out_value;

endmodule

/* tb/sv/servo_cmd_checker.sv */
`timescale 1ns / 1ps

module servo_cmd_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_rx_valid,
    input  logic                           i_rx_ready,
    input  logic [scl_pkg::RX_W-1:0]       i_rx_byte,
    input  logic                           i_cfg_valid,
    input  logic                           i_cfg_ready,
    input  logic [scl_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [scl_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_res_valid,
    input  logic                           i_res_ready,
    input  logic                           i_res_axis,
    input  logic [scl_pkg::PULSE_W-1:0]    i_res_pulse_width,
    input  logic [scl_pkg::VALUE_W-1:0]    i_res_angle_value,
    output int                             o_fail_count,
    output int                             o_pending,
    output int                             o_checked
);
    import scl_pkg::*;

    localparam int PULSE_DIVISOR = 1000;
    localparam int PULSE_SAT     = 65535;

    typedef struct packed {
        logic               axis;
        logic [PULSE_W-1:0] pulse_width;
        logic [VALUE_W-1:0] angle_value;
    } t_servo_cmd;

    t_servo_cmd servo_cmd_q [$];
    int         fail_count = 0;
    int         checked    = 0;

    // own copy of the registers
    logic [PERIOD_W-1:0] period_q;
    logic [VALUE_W-1:0]  pitch_lo;
    logic [VALUE_W-1:0]  pitch_hi;
    logic [VALUE_W-1:0]  yaw_lo;
    logic [VALUE_W-1:0]  yaw_hi;

    // own copy of the line state
    t_phase phase_q;
    t_kind  kind_q;
    logic   neg_q;
    int     mag_q;

    assign o_fail_count = fail_count;
    assign o_pending    = servo_cmd_q.size();
    assign o_checked    = checked;

    // advance the line parser by one byte, queue the servo command a line end yields
    task automatic parse_rx_byte(input logic [RX_W-1:0] c);
        int         lo;
        int         hi;
        int         pw;
        int         v;
        t_servo_cmd cmd;
        if (c == CH_LF || c == CH_CR) begin
            // a nonzero negative value is below every window
            if (kind_q != KIND_NONE && !(neg_q && mag_q != 0)) begin
                lo = (kind_q == KIND_YAW) ? int'(yaw_lo) : int'(pitch_lo);
                hi = (kind_q == KIND_YAW) ? int'(yaw_hi) : int'(pitch_hi);
                if (mag_q >= lo && mag_q <= hi) begin
                    pw = mag_q * int'(period_q) / PULSE_DIVISOR;
                    cmd.axis        = (kind_q == KIND_YAW) ? AXIS_YAW : AXIS_PITCH;
                    cmd.pulse_width = PULSE_W'((pw > PULSE_SAT) ? PULSE_SAT : pw);
                    cmd.angle_value = VALUE_W'(mag_q);
                    servo_cmd_q.push_back(cmd);
                end
            end
            phase_q = PH_START;
            kind_q  = KIND_NONE;
            neg_q   = 1'b0;
            mag_q   = 0;
        end else begin
            case (phase_q)
                PH_START: begin
                    if (c == CH_P_LO || c == CH_P_UP) begin
                        kind_q  = KIND_PITCH;
                        phase_q = PH_LEAD;
                    end else if (c == CH_Y_LO || c == CH_Y_UP) begin
                        kind_q  = KIND_YAW;
                        phase_q = PH_LEAD;
                    end else begin
                        kind_q  = KIND_NONE;
                        phase_q = PH_DONE;
                    end
                end
                PH_LEAD: begin
                    if (c == CH_SPACE || c == CH_TAB || c == CH_VT || c == CH_FF) begin
                        phase_q = PH_LEAD;
                    end else if (c == CH_MINUS) begin
                        neg_q   = 1'b1;
                        phase_q = PH_DIGITS;
                    end else if (c == CH_PLUS) begin
                        phase_q = PH_DIGITS;
                    end else if (c >= CH_ZERO && c <= CH_NINE) begin
                        mag_q   = int'(c - CH_ZERO);
                        phase_q = PH_DIGITS;
                    end else begin
                        phase_q = PH_DONE;
                    end
                end
                PH_DIGITS: begin
                    if (c >= CH_ZERO && c <= CH_NINE) begin
                        // magnitude saturates instead of wrapping
                        v     = mag_q * 10 + int'(c - CH_ZERO);
                        mag_q = (v > int'(ACC_MAX)) ? int'(ACC_MAX) : v;
                    end else begin
                        phase_q = PH_DONE;
                    end
                end
                default: begin
                    phase_q = PH_DONE;
                end
            endcase
        end
    endtask

    always @(posedge i_clk) begin
        t_servo_cmd want;
        if (!i_rst_n) begin
            period_q = PERIOD_RST;
            pitch_lo = PITCH_MIN_RST;
            pitch_hi = PITCH_MAX_RST;
            yaw_lo   = YAW_MIN_RST;
            yaw_hi   = YAW_MAX_RST;
            phase_q  = PH_START;
            kind_q   = KIND_NONE;
            neg_q    = 1'b0;
            mag_q    = 0;
            servo_cmd_q.delete();
        end else begin
            // result transfer against the oldest queued command
            if (i_res_valid && i_res_ready) begin
                if (servo_cmd_q.size() == 0) begin
                    $error("unexpected result: axis %0d pulse_width %0d angle_value %0d",
                           i_res_axis, i_res_pulse_width, i_res_angle_value);
                    fail_count++;
                end else begin
                    want = servo_cmd_q.pop_front();
                    checked++;
                    if (i_res_axis !== want.axis) begin
                        $error("axis: expected %0d, got %0d", want.axis, i_res_axis);
                        fail_count++;
                    end
                    if (i_res_pulse_width !== want.pulse_width) begin
                        $error("pulse_width: expected %0d, got %0d",
                               want.pulse_width, i_res_pulse_width);
                        fail_count++;
                    end
                    if (i_res_angle_value !== want.angle_value) begin
                        $error("angle_value: expected %0d, got %0d",
                               want.angle_value, i_res_angle_value);
                        fail_count++;
                    end
                end
            end

            // register write transfer, unknown indexes leave everything alone
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    REG_PWM_PERIOD: period_q = i_cfg_data;
                    REG_PITCH_MIN:  pitch_lo = i_cfg_data[VALUE_W-1:0];
                    REG_PITCH_MAX:  pitch_hi = i_cfg_data[VALUE_W-1:0];
                    REG_YAW_MIN:    yaw_lo   = i_cfg_data[VALUE_W-1:0];
                    REG_YAW_MAX:    yaw_hi   = i_cfg_data[VALUE_W-1:0];
                    default: ;
                endcase
            end

            // byte transfer
            if (i_rx_valid && i_rx_ready) begin
                parse_rx_byte(i_rx_byte);
            end
        end
    end

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 1ps

module testbench;
    import scl_pkg::*;

    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int CFG_SETTLE     = 8;
    localparam int DRAIN_CYCLES   = 12;
    localparam int PHASE_BYTES    = 130;
    localparam int RST_CYCLES     = 11;

    logic i_clk;
    logic i_rst_n;

    scl_rx_if  rx_if ();
    scl_cfg_if cfg_if ();
    scl_res_if res_if ();

    int fail_count;
    int pending;
    int checked;
    int bytes_sent       = 0;
    int lines_sent       = 0;
    int settings_applied = 0;
    int holds_done       = 0;
    int idle_cycles      = 0;
    bit steady           = 1'b0;
    bit hold_req         = 1'b0;

    // shadow of the written windows, only used to aim the stimulus
    int cur_period;
    int win_lo [2];
    int win_hi [2];

    servo_command_line_parser uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rx    (rx_if),
        .i_cfg   (cfg_if),
        .o_res   (res_if)
    );

    servo_cmd_checker u_checker (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_rx_valid        (rx_if.valid),
        .i_rx_ready        (rx_if.ready),
        .i_rx_byte         (rx_if.rx_byte),
        .i_cfg_valid       (cfg_if.valid),
        .i_cfg_ready       (cfg_if.ready),
        .i_cfg_index       (cfg_if.index),
        .i_cfg_data        (cfg_if.data),
        .i_res_valid       (res_if.valid),
        .i_res_ready       (res_if.ready),
        .i_res_axis        (res_if.axis),
        .i_res_pulse_width (res_if.pulse_width),
        .i_res_angle_value (res_if.angle_value),
        .o_fail_count      (fail_count),
        .o_pending         (pending),
        .o_checked         (checked)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if ((rx_if.valid && rx_if.ready) || (res_if.valid && res_if.ready) ||
            (cfg_if.valid && cfg_if.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $error("no transfer for %0d cycles, %0d results outstanding", idle_cycles, pending);
            $display("FAILED: results differ");
            $finish;
        end
    end

    // result side: random hold-off per result, one long stall on request
    initial begin
        int gap;
        res_if.ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            gap = steady ? 0 : $urandom_range(0, 3);
            if (hold_req) begin
                gap = HOLD_CYCLES;
                hold_req = 1'b0;
                holds_done++;
            end
            if (gap > 0) begin
                res_if.ready <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            res_if.ready <= 1'b1;
            do @(posedge i_clk); while (!(res_if.valid && res_if.ready));
            @(negedge i_clk);
        end
    end

    // one byte transfer after a random gap
    task automatic send_byte(input logic [RX_W-1:0] b);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            rx_if.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        rx_if.valid   <= 1'b1;
        rx_if.rx_byte <= b;
        do @(posedge i_clk); while (!(rx_if.valid && rx_if.ready));
        @(negedge i_clk);
        bytes_sent++;
        if (b == CH_LF || b == CH_CR) lines_sent++;
    endtask

    task automatic send_text(input string s);
        foreach (s[k]) send_byte(s[k]);
    endtask

    // value aimed mostly at the window and its edges
    function automatic int pick_value(input int lo, input int hi);
        int r;
        r = $urandom_range(0, 99);
        if (r < 55 && lo <= hi) return $urandom_range(hi, lo);
        if (r < 75) begin
            case ($urandom_range(0, 3))
                0: return (lo > 0) ? lo - 1 : 0;
                1: return lo;
                2: return hi;
                default: return hi + 1;
            endcase
        end
        if (r < 85) return $urandom_range(1024, 99999);
        return $urandom_range(0, 1023);
    endfunction

    // one command line: mostly well formed, the rest noise
    task automatic send_line();
        int              ax;
        int              v;
        int              n;
        int              digs [$];
        logic [RX_W-1:0] b;
        if ($urandom_range(0, 99) < 85) begin
            ax = $urandom_range(0, 1);
            if (ax == 0) b = $urandom_range(0, 1) ? CH_P_UP : CH_P_LO;
            else         b = $urandom_range(0, 1) ? CH_Y_UP : CH_Y_LO;
            send_byte(b);
            // leading blanks
            repeat ($urandom_range(0, 2)) begin
                case ($urandom_range(0, 3))
                    0: b = CH_SPACE;
                    1: b = CH_TAB;
                    2: b = CH_VT;
                    default: b = CH_FF;
                endcase
                send_byte(b);
            end
            // optional sign
            n = $urandom_range(0, 19);
            if (n < 2) send_byte(CH_MINUS);
            else if (n < 5) send_byte(CH_PLUS);
            // digits, sometimes none at all
            if ($urandom_range(0, 19) != 0) begin
                v = pick_value(win_lo[ax], win_hi[ax]);
                repeat (($urandom_range(0, 4) == 0) ? $urandom_range(1, 2) : 0) begin
                    send_byte(CH_ZERO);
                end
                digs.delete();
                do begin
                    digs.push_front(v % 10);
                    v = v / 10;
                end while (v > 0);
                foreach (digs[k]) send_byte(CH_ZERO + RX_W'(digs[k]));
            end
            // trailing junk after the number
            if ($urandom_range(0, 3) == 0) begin
                do b = RX_W'($urandom_range(0, 255));
                while ((b >= CH_ZERO && b <= CH_NINE) || b == CH_LF || b == CH_CR);
                send_byte(b);
                repeat ($urandom_range(0, 2)) begin
                    do b = RX_W'($urandom_range(0, 255)); while (b == CH_LF || b == CH_CR);
                    send_byte(b);
                end
            end
        end else begin
            repeat ($urandom_range(0, 6)) begin
                b = ($urandom_range(0, 7) == 0) ? '0 : RX_W'($urandom_range(0, 255));
                send_byte(b);
            end
        end
        send_byte($urandom_range(0, 1) ? CH_LF : CH_CR);
    endtask

    // stop offering, wait for every result and let the pipeline drain
    task automatic finish_phase();
        rx_if.valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (CFG_SETTLE) @(negedge i_clk);
    endtask

    task automatic run_lines(input int budget);
        int start;
        start = bytes_sent;
        while (bytes_sent - start < budget) send_line();
        finish_phase();
    endtask

    // one register write transfer
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= d;
        do @(posedge i_clk); while (!(cfg_if.valid && cfg_if.ready));
        @(negedge i_clk);
        case (idx)
            REG_PWM_PERIOD: cur_period = d;
            REG_PITCH_MIN:  win_lo[0]  = d[VALUE_W-1:0];
            REG_PITCH_MAX:  win_hi[0]  = d[VALUE_W-1:0];
            REG_YAW_MIN:    win_lo[1]  = d[VALUE_W-1:0];
            REG_YAW_MAX:    win_hi[1]  = d[VALUE_W-1:0];
            default: ;
        endcase
    endtask

    // full register set, then junk writes to the unused indexes
    task automatic set_registers(input logic [CFG_DATA_W-1:0] period,
                                 input logic [CFG_DATA_W-1:0] p_lo,
                                 input logic [CFG_DATA_W-1:0] p_hi,
                                 input logic [CFG_DATA_W-1:0] y_lo,
                                 input logic [CFG_DATA_W-1:0] y_hi);
        write_reg(REG_PWM_PERIOD, period);
        write_reg(REG_PITCH_MIN, p_lo);
        write_reg(REG_PITCH_MAX, p_hi);
        write_reg(REG_YAW_MIN, y_lo);
        write_reg(REG_YAW_MAX, y_hi);
        for (int k = REG_YAW_MAX + 1; k < (1 << CFG_IDX_W); k++) begin
            write_reg(CFG_IDX_W'(k), CFG_DATA_W'($urandom));
        end
        cfg_if.valid <= 1'b0;
        settings_applied++;
    endtask

    // stimulus and verdict
    initial begin
        int lo;
        int hi;
        int ylo;
        int yhi;
        rx_if.valid   <= 1'b0;
        rx_if.rx_byte <= '0;
        cfg_if.valid  <= 1'b0;
        cfg_if.index  <= '0;
        cfg_if.data   <= '0;
        i_rst_n       <= 1'b0;
        cur_period = PERIOD_RST;
        win_lo[0]  = PITCH_MIN_RST;
        win_hi[0]  = PITCH_MAX_RST;
        win_lo[1]  = YAW_MIN_RST;
        win_hi[1]  = YAW_MAX_RST;
        repeat (RST_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset windows: both edges, empty line, unknown axis, blanks, plus sign, junk stop
        send_text("p20\n");
        send_text("Y160\r");
        send_text("\n");
        send_text("q7\n");
        send_text("y\t+99z\n");
        finish_phase();

        // widest windows at full-scale period: pulse saturation, negative zero
        set_registers(16'hFFFF, 16'hFC00, 16'hFFFF, 16'h0000, 16'd1000);
        send_text("P1023\n");
        send_text("y-0\r");
        hold_req = 1'b1;
        run_lines(PHASE_BYTES);

        // zero period, single-value pitch window
        set_registers(16'd0, 16'd1000, 16'd1000, 16'd500, 16'd600);
        run_lines(PHASE_BYTES);

        // pitch minimum above maximum, back-to-back transfers on both sides
        set_registers(CFG_DATA_W'($urandom), 16'd800, 16'd100,
                      {6'($urandom), 10'd0}, {6'($urandom), 10'd1023});
        steady = 1'b1;
        run_lines(PHASE_BYTES);
        steady = 1'b0;

        // random windows
        repeat (3) begin
            lo  = $urandom_range(0, 600);
            hi  = lo + $urandom_range(0, 423);
            ylo = $urandom_range(0, 600);
            yhi = ylo + $urandom_range(0, 423);
            set_registers(CFG_DATA_W'($urandom), {6'($urandom), 10'(lo)},
                          {6'($urandom), 10'(hi)}, {6'($urandom), 10'(ylo)},
                          {6'($urandom), 10'(yhi)});
            run_lines(PHASE_BYTES);
        end

        repeat (DRAIN_CYCLES) @(negedge i_clk);
        $display("run covered %0d bytes in %0d lines under %0d register settings",
                 bytes_sent, lines_sent, settings_applied + 1);
        $display("%0d servo commands compared, %0d long result stalls, %0d mismatches",
                 checked, holds_done, fail_count);
        if (fail_count == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
